// ===== design/base64_stream_encoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Concurrent assertion helpers shared by the encoder modules; empty under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset-qualified
`define B64E_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Next-cycle implication, reset-qualified
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("encoder check failed");

`else

`define B64E_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder package
// Character constants, the sextet-to-ASCII mapping and the group result type.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned CHARS_N = 4;
    localparam int unsigned COUNT_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_PAD    = 7'h3D; // '='
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 7'h2B; // '+'
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 7'h2F; // '/'
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2D; // '-'
    localparam logic [CHAR_W-1:0] CHAR_UNDER  = 7'h5F; // '_'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_BASE = 7'h47; // 'a' minus 26
    localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 7'd4;    // 52 minus '0'

    // Characters produced by one input item, first character in slot 0
    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        logic                           last;
        logic [CHARS_N-1:0][CHAR_W-1:0] chars;
    } b64e_res_t;

    // Map one 6-bit value to its alphabet character
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] idx,
                                                      input logic url);
        logic [CHAR_W-1:0] wide;
        wide = {1'b0, idx};
        if (idx < 6'd26) begin
            sextet_char = CHAR_UPPER_A + wide;
        end else if (idx < 6'd52) begin
            sextet_char = CHAR_LOWER_BASE + wide;
        end else if (idx < 6'd62) begin
            sextet_char = wide - DIGIT_OFFSET;
        end else if (idx == 6'd62) begin
            sextet_char = url ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            sextet_char = url ? CHAR_UNDER : CHAR_SLASH;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/b64e_group.sv =====
// ----------------------------------------------------------------------------
// Base64 group builder
// Holds the partial three-byte group and works out the characters that one
// byte causes: four for a complete group, a padded or short flush on last.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_encoder_unit_macros.svh"

module b64e_group
    import b64e_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,   // byte consumed this cycle
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       url_safe,
    output b64e_res_t       res
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  fill_reg, fill_next;
    logic [23:0] group;
    logic [5:0]  sx0, sx1, sx2, sx3;
    logic        full;

    assign full = fill_reg[1];

    // Assemble the 24-bit group, oldest byte highest
    always_comb begin
        if (full) begin
            group = {held_reg, data_byte};
        end else if (fill_reg == 2'd1) begin
            group = {held_reg[7:0], data_byte, 8'h00};
        end else begin
            group = {data_byte, 16'h0000};
        end
    end

    assign sx0 = group[23:18];
    assign sx1 = group[17:12];
    assign sx2 = group[11:6];
    assign sx3 = group[5:0];

    // Choose character slots and how many of them count
    always_comb begin
        res.last     = last_byte;
        res.chars[0] = sextet_char(sx0, url_safe);
        res.chars[1] = sextet_char(sx1, url_safe);
        res.chars[2] = sextet_char(sx2, url_safe);
        res.chars[3] = sextet_char(sx3, url_safe);
        if (full) begin
            res.count = 3'd4;
        end else if (!last_byte) begin
            res.count = 3'd0;
        end else if (fill_reg == 2'd1) begin
            res.chars[3] = CHAR_PAD;
            res.count    = url_safe ? 3'd3 : 3'd4;
        end else begin
            res.chars[2] = CHAR_PAD;
            res.chars[3] = CHAR_PAD;
            res.count    = url_safe ? 3'd2 : 3'd4;
        end
    end

    // Advance the held bytes; clear on a complete group or on last
    always_comb begin
        held_next = held_reg;
        fill_next = fill_reg;
        if (step_en) begin
            if (full || last_byte) begin
                held_next = 16'h0000;
                fill_next = 2'd0;
            end else begin
                held_next = {held_reg[7:0], data_byte};
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 16'h0000;
            fill_reg <= 2'd0;
        end else begin
            held_reg <= held_next;
            fill_reg <= fill_next;
        end
    end

    `B64E_ASSERT_IMPLIES(a_fill_range, aclk, aresetn, 1'b1, fill_reg != 2'd3)
    `B64E_ASSERT_NEXT(a_last_clears, aclk, aresetn, step_en && last_byte, fill_reg == 2'd0)
    `B64E_ASSERT_IMPLIES(a_emit_cause, aclk, aresetn, step_en && (res.count != 3'd0),
                         (fill_reg == 2'd2) || last_byte)

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Takes a byte stream and sends out Base64 ASCII characters, one per item.
// Each byte is taken into an input register; a byte that completes a group
// of three, or that carries tlast, loads four characters (a short or padded
// flush on tlast) into a four-slot result buffer, and the buffer sends them
// one per cycle while m_tready is high. Bytes that only fill the group are
// accepted every cycle; a byte that produces characters waits in the input
// register until the buffer is empty or its final character is being taken.
// The single-character output port sets the rate, and the first character
// passes through the input register and the result buffer before it leaves.
// cfg_wr_data selects the URL-safe alphabet without padding (1, the reset
// value) or the standard alphabet with '=' padding (0); write it only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_encoder_unit_macros.svh"

module base64_stream_encoder_unit
    import b64e_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,  // url_safe_mode
    // byte input
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,      // [7:0] data_byte
    input  wire logic       s_tlast,      // last_byte
    // character output
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,      // [6:0] out_char, [7] zero
    output logic            m_tlast       // last_char
);

    logic mode_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [COUNT_W-1:0]             cnt_reg, cnt_next;
    logic                           last_reg, last_next;
    logic [CHARS_N-1:0][CHAR_W-1:0] chars_reg, chars_next;

    b64e_res_t res;
    logic      buf_free;
    logic      stage_go;
    logic      emit_load;
    logic      pop;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    b64e_group u_group (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (stage_go),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .url_safe  (mode_reg),
        .res       (res)
    );

    // Handshake decisions
    assign pop       = m_tvalid && m_tready;
    assign buf_free  = (cnt_reg == '0) || ((cnt_reg == COUNT_W'(1)) && m_tready);
    assign stage_go  = in_valid_reg && ((res.count == '0) || buf_free);
    assign emit_load = stage_go && (res.count != '0);
    assign s_tready  = !in_valid_reg || stage_go;

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (stage_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result buffer: load a group, or shift one character out
    always_comb begin
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        chars_next = chars_reg;
        if (emit_load) begin
            cnt_next   = res.count;
            last_next  = res.last;
            chars_next = res.chars;
        end else if (pop) begin
            cnt_next = cnt_reg - COUNT_W'(1);
            for (int i = 0; i < CHARS_N - 1; i++) begin
                chars_next[i] = chars_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
    end

    // Drive the output item from the buffer head
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {1'b0, chars_reg[0]};
    assign m_tlast  = last_reg && (cnt_reg == COUNT_W'(1));

    `B64E_ASSERT_IMPLIES(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= COUNT_W'(CHARS_N))
    `B64E_ASSERT_IMPLIES(a_load_when_free, aclk, aresetn, emit_load, buf_free)
    `B64E_ASSERT_NEXT(a_load_fills, aclk, aresetn, emit_load, m_tvalid)

endmodule

`default_nettype wire

// ===== dv/base64_stream_encoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Feeds byte messages through the encoder under both alphabets and checks
// every character, and its end marker, against a local Base64 predictor.
// The input and output sides idle and stall at random, and the mode is
// changed between phases, also while part of a group is still held.
// ----------------------------------------------------------------------------

module base64_stream_encoder_unit_tb;
    import b64e_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_byte_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              tail;
    } enc_char_t;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 230;
    localparam int PRINT_CAP     = 40;

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // DUT inputs, all driven to known values from time zero
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b1;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;
    logic       s_tlast     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state
    logic [15:0] held_bytes = 16'h0000;
    logic [1:0]  group_fill = 2'd0;
    logic        url_mode   = 1'b1;

    feed_byte_t  bytes_to_send[$];
    enc_char_t   pending_chars[$];
    feed_byte_t  next_byte;
    enc_char_t   want_char;

    int          feed_gap     = 0;
    int          drain_stall  = 0;
    bit          feed_steady  = 1'b0;
    bit          drain_steady = 1'b0;
    int          fail_count   = 0;
    int          cycle_count  = 0;

    base64_stream_encoder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one, none in a steady stretch
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [5:0] idx);
        logic [7:0] ch;
        ch = B64_ALPHABET[8*(63 - int'(idx)) +: 8];
        if (url_mode && idx == 6'd62)
            ch = {1'b0, CHAR_MINUS};
        else if (url_mode && idx == 6'd63)
            ch = {1'b0, CHAR_UNDER};
        return ch[CHAR_W-1:0];
    endfunction

    function automatic void expect_char(input logic [CHAR_W-1:0] code, input logic tail);
        enc_char_t c;
        c.code = code;
        c.tail = tail;
        pending_chars.push_back(c);
    endfunction

    // Advance the encoder state by one byte and queue the characters it yields
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic [23:0] grp;
        if (group_fill == 2'd2) begin
            grp = {held_bytes, b};
            expect_char(sextet_to_ascii(grp[23:18]), 1'b0);
            expect_char(sextet_to_ascii(grp[17:12]), 1'b0);
            expect_char(sextet_to_ascii(grp[11:6]), 1'b0);
            expect_char(sextet_to_ascii(grp[5:0]), last);
            held_bytes = 16'h0000;
            group_fill = 2'd0;
        end else if (!last) begin
            held_bytes = {held_bytes[7:0], b};
            group_fill = group_fill + 2'd1;
        end else begin
            if (group_fill == 2'd0) begin
                grp = {b, 16'h0000};
                expect_char(sextet_to_ascii(grp[23:18]), 1'b0);
                expect_char(sextet_to_ascii(grp[17:12]), url_mode);
                if (!url_mode) begin
                    expect_char(CHAR_PAD, 1'b0);
                    expect_char(CHAR_PAD, 1'b1);
                end
            end else begin
                grp = {held_bytes[7:0], b, 8'h00};
                expect_char(sextet_to_ascii(grp[23:18]), 1'b0);
                expect_char(sextet_to_ascii(grp[17:12]), 1'b0);
                expect_char(sextet_to_ascii(grp[11:6]), url_mode);
                if (!url_mode)
                    expect_char(CHAR_PAD, 1'b1);
            end
            held_bytes = 16'h0000;
            group_fill = 2'd0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic add_byte(input logic [7:0] data, input logic last);
        feed_byte_t f;
        f.data = data;
        f.last = last;
        bytes_to_send.push_back(f);
    endtask

    // Queue one message of random content; leave it open if close is clear
    task automatic add_message(input int len, input bit close);
        int r;
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                d = 8'hFF;
            else if (r < 18)
                d = 8'h00;
            else
                d = 8'($urandom);
            add_byte(d, close && (i == len - 1));
        end
    endtask

    // Hold until every byte is taken and every character has come out
    task automatic wait_drained();
        @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_tvalid || pending_chars.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic url);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= url;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        url_mode     = url;
    endtask

    // Byte driver: predict on each accepted item, then load the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            feed_gap  = 0;
        end else begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    s_tvalid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    next_byte = bytes_to_send.pop_front();
                    s_tdata  <= next_byte.data;
                    s_tlast  <= next_byte.last;
                    s_tvalid <= 1'b1;
                    feed_gap  = pick_gap(feed_steady);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Character monitor: compare each accepted item with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            drain_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want_char = pending_chars.pop_front();
                    if (m_tdata !== {1'b0, want_char.code})
                        report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                                  m_tdata, want_char.code));
                    if (m_tlast !== want_char.tail)
                        report_mismatch($sformatf("tlast %0b, want %0b on char 0x%02h",
                                                  m_tlast, want_char.tail, want_char.code));
                end
            end
            if (drain_stall > 0) begin
                drain_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                drain_stall = pick_gap(drain_steady);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int sent;
        int phase;
        int len;
        int r;
        bit close;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // URL-safe form from reset: single bytes at both extremes, a two-byte
        // flush and a full group, together hitting the two URL characters
        @(negedge aclk);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFB, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFB, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBE, 1'b1);
        // open message: two bytes held across the mode change
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        wait_drained();

        // Standard form: finish the held group, then padded flushes and full groups
        write_mode(1'b0);
        @(negedge aclk);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFB, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h5A, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        wait_drained();

        // Random phases, URL-safe, then standard, then a random alphabet, some ending mid-message
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            if (phase == 0)
                write_mode(1'b1);
            else if (phase == 1)
                write_mode(1'b0);
            else
                write_mode(1'($urandom_range(0, 1)));
            feed_steady  = ($urandom_range(0, 3) == 0);
            drain_steady = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
            for (int k = 0; k < 40 && sent < RANDOM_BYTES; k += len) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 6);
                else if (r < 92)
                    len = $urandom_range(7, 15);
                else
                    len = $urandom_range(16, 40);
                close = (k + len < 40) || ($urandom_range(0, 2) != 0);
                add_message(len, close);
                sent += len;
            end
            wait_drained();
            phase++;
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
